[rtl/mbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants of the markup byte tokenizer
// Character codes, scan modes, token kinds and the token bundle that the
// front hands to the back through the queue.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int unsigned MaxTokens  = 4;
  localparam int unsigned CountW     = $clog2(MaxTokens + 1);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);
  localparam logic [15:0] PosMax     = 16'hFFFF;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [3:0] {
    ModeStart     = 4'd0,
    ModeLt        = 4'd1,
    ModeLtBang    = 4'd2,
    ModeLtBangDash = 4'd3,
    ModeCom0      = 4'd4,
    ModeCom1      = 4'd5,
    ModeCom2      = 4'd6,
    ModeDecl      = 4'd7,
    ModePi        = 4'd8,
    ModePiQ       = 4'd9,
    ModeQstr      = 4'd10,
    ModeUstr      = 4'd11
  } scan_mode_e;

  typedef enum logic [2:0] {
    KindLt    = 3'd0,
    KindGt    = 3'd1,
    KindSlash = 3'd2,
    KindEq    = 3'd3,
    KindSbyte = 3'd4,
    KindSend  = 3'd5,
    KindEof   = 3'd6
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  content;
    logic [15:0] line;
    logic [15:0] column;
  } token_t;

  typedef struct packed {
    logic [CountW-1:0]         count;
    token_t [MaxTokens-1:0]    tok;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return is_space(c) || (c == ChLt) || (c == ChGt) || (c == ChEq) || (c == ChSlash);
  endfunction

  function automatic token_t make_tok(input token_kind_e kind, input logic [7:0] content,
                                      input logic [15:0] line, input logic [15:0] column);
    token_t t;
    t.kind    = kind;
    t.content = content;
    t.line    = line;
    t.column  = column;
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/mbt_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_in_if: byte input channel
// Valid/ready channel carrying one text byte and its end flag.
// ----------------------------------------------------------------------------
interface mbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_data;

  modport source (output valid, data_byte, byte_valid, end_of_data, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_data, output ready);
endinterface
`default_nettype wire

[rtl/mbt_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_out_if: token output channel
// Valid/ready channel carrying one token with its start position.
// ----------------------------------------------------------------------------
interface mbt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  content_byte;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic        last_result;

  modport source (output valid, token_kind, content_byte, token_line, token_column,
                  last_result, input ready);
  modport sink   (input valid, token_kind, content_byte, token_line, token_column,
                  last_result, output ready);
endinterface
`default_nettype wire

[rtl/mbt_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_front: scanner front end
// Accepts one byte per transaction, advances the scan mode and position
// counters, and pushes the bundle of tokens that the byte produces.
// ----------------------------------------------------------------------------
module mbt_front
  import mbt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  mbt_in_if.sink  byte_i,
  input  logic    full_i,
  output logic    push_o,
  output bundle_t bundle_o
);

  scan_mode_e  mode_q, mode_d;
  logic [15:0] line_q, line_d, col_q, col_d;
  logic [15:0] sline_q, sline_d, scol_q, scol_d;
  logic        fin_q, fin_d;
  logic        redo;
  logic        accept;
  logic [7:0]  c;
  logic [CountW-1:0] n;
  token_t [MaxTokens-1:0] tok;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && !full_i;
  assign c            = byte_i.data_byte;

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    fin_d   = fin_q;
    redo    = 1'b0;
    n       = '0;
    tok     = '0;
    if (fin_q) begin
      tok[n[1:0]] = make_tok(KindEof, 8'h00, line_q, col_q);
      n = n + 1'b1;
    end else begin
      if (byte_i.byte_valid) begin
        unique case (mode_q)
          ModeLt: begin
            if (c == ChBang) begin
              mode_d = ModeLtBang;
            end else if (c == ChQuest) begin
              mode_d = ModePi;
            end else begin
              tok[n[1:0]] = make_tok(KindLt, 8'h00, sline_q, scol_q);
              n = n + 1'b1;
              redo = 1'b1;
            end
          end
          ModeLtBang, ModeLtBangDash: begin
            if (c == ChDash) begin
              mode_d = (mode_q == ModeLtBang) ? ModeLtBangDash : ModeCom0;
            end else if (c == ChGt) begin
              mode_d = ModeStart;
            end else begin
              mode_d = ModeDecl;
            end
          end
          ModeCom0: mode_d = (c == ChDash) ? ModeCom1 : ModeCom0;
          ModeCom1: mode_d = (c == ChDash) ? ModeCom2 : ModeCom0;
          ModeCom2: begin
            if (c == ChGt) begin
              mode_d = ModeStart;
            end else if (c != ChDash) begin
              mode_d = ModeCom0;
            end
          end
          ModeDecl: begin
            if (c == ChGt) begin
              mode_d = ModeStart;
            end
          end
          ModePi: begin
            if (c == ChQuest) begin
              mode_d = ModePiQ;
            end
          end
          ModePiQ: begin
            if (c == ChGt) begin
              mode_d = ModeStart;
            end else if (c != ChQuest) begin
              mode_d = ModePi;
            end
          end
          ModeQstr: begin
            if (c == ChQuote) begin
              tok[n[1:0]] = make_tok(KindSend, 8'h00, sline_q, scol_q);
              n = n + 1'b1;
              mode_d = ModeStart;
            end else begin
              tok[n[1:0]] = make_tok(KindSbyte, c, sline_q, scol_q);
              n = n + 1'b1;
            end
          end
          ModeUstr: begin
            if (is_stop(c)) begin
              tok[n[1:0]] = make_tok(KindSend, 8'h00, sline_q, scol_q);
              n = n + 1'b1;
              redo = 1'b1;
            end else begin
              tok[n[1:0]] = make_tok(KindSbyte, c, sline_q, scol_q);
              n = n + 1'b1;
            end
          end
          default: redo = 1'b1;
        endcase
        if (redo) begin
          mode_d = ModeStart;
          if (is_space(c)) begin
            mode_d = ModeStart;
          end else if (c == ChLt) begin
            sline_d = line_q;
            scol_d  = col_q;
            mode_d  = ModeLt;
          end else if (c == ChGt) begin
            tok[n[1:0]] = make_tok(KindGt, 8'h00, line_q, col_q);
            n = n + 1'b1;
          end else if (c == ChSlash) begin
            tok[n[1:0]] = make_tok(KindSlash, 8'h00, line_q, col_q);
            n = n + 1'b1;
          end else if (c == ChEq) begin
            tok[n[1:0]] = make_tok(KindEq, 8'h00, line_q, col_q);
            n = n + 1'b1;
          end else begin
            sline_d = line_q;
            scol_d  = col_q;
            if (c == ChQuote) begin
              mode_d = ModeQstr;
            end else begin
              tok[n[1:0]] = make_tok(KindSbyte, c, line_q, col_q);
              n = n + 1'b1;
              mode_d = ModeUstr;
            end
          end
        end
        if (c == ChLf) begin
          if (line_q != PosMax) begin
            line_d = line_q + 16'd1;
          end
          col_d = 16'd1;
        end else if (col_q != PosMax) begin
          col_d = col_q + 16'd1;
        end
      end
      if (byte_i.end_of_data) begin
        if (mode_d == ModeLt) begin
          tok[n[1:0]] = make_tok(KindLt, 8'h00, sline_d, scol_d);
          n = n + 1'b1;
        end else if (mode_d == ModeQstr || mode_d == ModeUstr) begin
          tok[n[1:0]] = make_tok(KindSend, 8'h00, sline_d, scol_d);
          n = n + 1'b1;
        end
        tok[n[1:0]] = make_tok(KindEof, 8'h00, line_d, col_d);
        n = n + 1'b1;
        mode_d = ModeStart;
        fin_d  = 1'b1;
      end
    end
  end

  assign push_o         = accept && (n != '0);
  assign bundle_o.count = n;
  assign bundle_o.tok   = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeStart;
      line_q  <= 16'd1;
      col_q   <= 16'd1;
      sline_q <= 16'd1;
      scol_q  <= 16'd1;
      fin_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      fin_q   <= fin_d;
    end
  end

endmodule
`default_nettype wire

[rtl/mbt_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_queue: token bundle queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module mbt_queue
  import mbt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    empty_o
);

  bundle_t            mem_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [QCountW-1:0] count_q;
  logic               do_pop;

  assign full_o  = (count_q == QCountW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/mbt_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_back: token serializer
// Walks the head bundle one token per cycle into the output register while the
// receiver takes tokens, and marks the last token of each bundle.
// ----------------------------------------------------------------------------
module mbt_back
  import mbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   head_i,
  input  logic      empty_i,
  output logic      pop_o,
  mbt_out_if.source token_o
);

  localparam int unsigned IdxW = $clog2(MaxTokens);

  logic              out_valid_q, out_valid_d;
  token_t            tok_q;
  logic              last_q, last_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              load;

  assign load   = !out_valid_q || token_o.ready;
  assign last_d = ({1'b0, idx_q} + 1'b1) == head_i.count;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        if (last_d) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      tok_q  <= head_i.tok[idx_q];
      last_q <= last_d;
    end
  end

  assign token_o.valid        = out_valid_q;
  assign token_o.token_kind   = tok_q.kind;
  assign token_o.content_byte = tok_q.content;
  assign token_o.token_line   = tok_q.line;
  assign token_o.token_column = tok_q.column;
  assign token_o.last_result  = last_q;

endmodule
`default_nettype wire

[rtl/markup_byte_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// markup_byte_tokenizer: streaming markup tokenizer
// Bytes enter on byte_i, one per transaction, with byte_valid and
// end_of_data flags. Tokens leave on token_o, one per transaction, each with
// its kind, content byte, start line and column; last_result marks the last
// token caused by one input transaction. A byte yields zero to four tokens.
// The front end classifies a byte in the cycle it is accepted and pushes its
// tokens as one bundle into a four-entry queue; the back end drains the head
// bundle one token per cycle through an output register while the receiver
// takes tokens. The first token passes through the queue entry and then the
// output register before it is valid. Input is taken every cycle while the
// queue has room; output runs at one token per cycle while the receiver is
// ready, so sustained byte rate is set by how many tokens each byte yields.
// Reset returns the scanner to token start at line 1, column 1 and empties
// the queue and output register. When the receiver stalls, the output token
// holds, the queue fills and byte_i.ready drops once four bundles wait.
// After the end token every further transaction yields one end token.
// ----------------------------------------------------------------------------
module markup_byte_tokenizer
  import mbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mbt_in_if.sink    byte_i,
  mbt_out_if.source token_o
);

  logic    push, full, pop, empty;
  bundle_t push_bundle, head_bundle;

  mbt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  mbt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (push_bundle),
    .full_o   (full),
    .pop_i    (pop),
    .head_o   (head_bundle),
    .empty_o  (empty)
  );

  mbt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_bundle),
    .empty_i (empty),
    .pop_o   (pop),
    .token_o (token_o)
  );

endmodule
`default_nettype wire
